// ===== sv/jsc_pkg.sv =====
`timescale 1ns / 1ps
package jsc_pkg;

    localparam int DEF_MAX_DEPTH     = 32;
    localparam int DEF_POSITION_BITS = 32;
    localparam int EV_MAX            = 8;
    localparam int EV_IDX_W          = $clog2(EV_MAX);
    localparam int CNT_W             = $clog2(EV_MAX + 1);
    localparam int QUEUE_DEPTH       = 4;
    localparam int S_TDATA_W         = 8;
    localparam int M_TDATA_W         = 56;
    localparam int M_FIELD_W         = 49;

    // flag bit positions
    localparam int FL_INKEY   = 0;
    localparam int FL_HAVEKEY = 1;
    localparam int FL_WANT    = 2;
    localparam int FL_DONE    = 3;
    localparam int FL_ERR     = 4;

    // frame: bit 2 set for an array, bits 1:0 the position inside the frame
    localparam logic [2:0] FRAME_OBJ = 3'b000;
    localparam logic [2:0] FRAME_ARR = 3'b100;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        EV_PROGRESS    = 3'd0,
        EV_KEY_BYTE    = 3'd1,
        EV_KEY_END     = 3'd2,
        EV_VALUE_START = 3'd3,
        EV_VALUE_END   = 3'd4,
        EV_COMPLETE    = 3'd5,
        EV_ERROR       = 3'd6,
        EV_IGNORED     = 3'd7
    } ev_code_t;

    typedef enum logic [9:0] {
        SM_NORMAL = 10'b00_0000_0001,
        SM_STR    = 10'b00_0000_0010,
        SM_ESC    = 10'b00_0000_0100,
        SM_HEX    = 10'b00_0000_1000,
        SM_LINE   = 10'b00_0001_0000,
        SM_BLOCK  = 10'b00_0010_0000,
        SM_STAR   = 10'b00_0100_0000,
        SM_NUM    = 10'b00_1000_0000,
        SM_LIT    = 10'b01_0000_0000,
        SM_SLASH  = 10'b10_0000_0000
    } mode_t;

    typedef struct packed {
        ev_code_t    code;
        logic [7:0]  key;
        logic [31:0] pos;
    } event_t;

    typedef struct packed {
        event_t [EV_MAX-1:0] ev;
        logic [CNT_W-1:0]    cnt;
        logic [5:0]          depth;
    } bundle_t;

    function automatic logic [7:0] lit_char(logic [1:0] which, logic [2:0] idx);
        logic [7:0] r;
        case ({which, idx})
            5'b00_000: r = 8'h74;
            5'b00_001: r = 8'h72;
            5'b00_010: r = 8'h75;
            5'b00_011: r = 8'h65;
            5'b01_000: r = 8'h66;
            5'b01_001: r = 8'h61;
            5'b01_010: r = 8'h6C;
            5'b01_011: r = 8'h73;
            5'b01_100: r = 8'h65;
            5'b10_000: r = 8'h6E;
            5'b10_001: r = 8'h75;
            5'b10_010: r = 8'h6C;
            5'b10_011: r = 8'h6C;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lit_len(logic [1:0] which);
        logic [2:0] r;
        case (which)
            2'd0:    r = 3'd4;
            2'd1:    r = 3'd5;
            2'd2:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/streaming_json_syntax_checker.sv =====
`timescale 1ns / 1ps
// Relaxed JSON checker taking one text byte per word on the slave side; tuser
// set starts a new document. Each byte yields one or more result words (up to
// eight) on the master side, the last of them flagged by tlast. A byte is
// accepted every cycle as long as it yields a single word and m_tready stays high;
// bytes that yield several words (decoded key bytes, lone surrogates, closing
// events) go out one word at a time, and a four-entry queue between the scanner
// and the output register absorbs such bursts. Result words pass through the
// queue and then the output register. The nesting stack sits in a RAM of
// MAX_DEPTH entries that needs no clearing after reset.
module streaming_json_syntax_checker #(
    parameter int MAX_DEPTH     = jsc_pkg::DEF_MAX_DEPTH,
    parameter int POSITION_BITS = jsc_pkg::DEF_POSITION_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jsc_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] byte_in
    input  logic [0:0]                    s_tuser,  // [0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] event_res, [10:3] key_byte, [42:11] position, [48:43] depth, rest zero
    output logic [jsc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import jsc_pkg::*;

    logic    f_valid, q_ready, q_valid, b_ready;
    bundle_t f_bundle, q_bundle;

    jsc_front #(
        .MAX_DEPTH     (MAX_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (q_ready),
        .in_cmd     (s_tuser[0]),
        .in_byte    (s_tdata),
        .out_valid  (f_valid),
        .out_bundle (f_bundle)
    );

    jsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (f_valid),
        .in_ready   (q_ready),
        .in_bundle  (f_bundle),
        .out_valid  (q_valid),
        .out_ready  (b_ready),
        .out_bundle (q_bundle)
    );

    jsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (b_ready),
        .in_bundle (q_bundle),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assign s_tready = q_ready;

endmodule

// ===== sv/jsc_ram.sv =====
`timescale 1ns / 1ps
module jsc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/jsc_front.sv =====
`timescale 1ns / 1ps
module jsc_front #(
    parameter int MAX_DEPTH     = jsc_pkg::DEF_MAX_DEPTH,
    parameter int POSITION_BITS = jsc_pkg::DEF_POSITION_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             in_cmd,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    output jsc_pkg::bundle_t out_bundle
);
    import jsc_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PB = POSITION_BITS;

    typedef struct packed {
        mode_t         mode;
        logic [2:0]    nphase;
        logic [1:0]    lwhich;
        logic [2:0]    lidx;
        logic [2:0]    hleft;
        logic [15:0]   hacc;
        logic          hheld;
        logic [15:0]   hval;
        logic [4:0]    fl;
        logic [2:0]    top;
        logic [2:0]    second;
        logic [LW-1:0] level;
    } st_t;

    typedef struct packed {
        st_t                 st;
        event_t [EV_MAX-1:0] ev;
        logic [CNT_W-1:0]    cnt;
        logic [PB-1:0]       cur;
        logic                push;
        logic [2:0]          wdata;
        logic [AW-1:0]       waddr;
        logic                pop;
        logic                redo;
    } scan_t;

    localparam st_t ST_CLEAR = '{mode: SM_NORMAL, nphase: 3'd0, lwhich: 2'd0, lidx: 3'd0,
                                 hleft: 3'd0, hacc: 16'd0, hheld: 1'b0, hval: 16'd0,
                                 fl: 5'd0, top: 3'd0, second: 3'd0, level: '0};

    st_t           st_reg, st_next;
    logic [PB-1:0] idx_reg, idx_next;
    logic          use_ram_reg, use_ram_next;
    logic [2:0]    ram_rdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic          accept;
    scan_t         scan;

    function automatic logic is_ws(logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    endfunction

    function automatic logic is_num_char(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic scan_t emit(scan_t s, ev_code_t code, logic [7:0] b, logic [PB-1:0] pos);
        if (s.cnt < CNT_W'(EV_MAX)) begin
            s.ev[s.cnt[EV_IDX_W-1:0]] = '{code: code, key: b, pos: 32'(pos)};
            s.cnt = s.cnt + 1'b1;
        end
        return s;
    endfunction

    function automatic scan_t fail(scan_t s);
        s.st.fl[FL_ERR] = 1'b1;
        return emit(s, EV_ERROR, 8'h00, s.cur);
    endfunction

    function automatic scan_t key_out(scan_t s, logic [7:0] b);
        if (s.st.level == LW'(1)) begin
            s = emit(s, EV_KEY_BYTE, b, s.cur);
        end
        return s;
    endfunction

    function automatic scan_t utf8_out(scan_t s, logic [20:0] cp);
        if (cp < 21'h80) begin
            s = key_out(s, cp[7:0]);
        end else if (cp < 21'h800) begin
            s = key_out(s, 8'hC0 | {3'b000, cp[10:6]});
            s = key_out(s, 8'h80 | {2'b00, cp[5:0]});
        end else if (cp < 21'h10000) begin
            s = key_out(s, 8'hE0 | {4'h0, cp[15:12]});
            s = key_out(s, 8'h80 | {2'b00, cp[11:6]});
            s = key_out(s, 8'h80 | {2'b00, cp[5:0]});
        end else begin
            s = key_out(s, 8'hF0 | {5'd0, cp[20:18]});
            s = key_out(s, 8'h80 | {2'b00, cp[17:12]});
            s = key_out(s, 8'h80 | {2'b00, cp[11:6]});
            s = key_out(s, 8'h80 | {2'b00, cp[5:0]});
        end
        return s;
    endfunction

    function automatic scan_t flush_high(scan_t s);
        if (s.st.hheld) begin
            s = utf8_out(s, {5'd0, s.st.hval});
            s.st.hheld = 1'b0;
        end
        return s;
    endfunction

    function automatic scan_t mark_value_start(scan_t s);
        if (s.st.level == LW'(1) && s.st.fl[FL_WANT]) begin
            s = emit(s, EV_VALUE_START, 8'h00, s.cur);
            s.st.fl[FL_WANT] = 1'b0;
        end
        return s;
    endfunction

    function automatic scan_t span_end(scan_t s, logic [PB-1:0] pos);
        if (s.st.level == LW'(1) && s.st.fl[FL_HAVEKEY] && !s.st.fl[FL_WANT]) begin
            s = emit(s, EV_VALUE_END, 8'h00, pos);
            s.st.fl[FL_HAVEKEY] = 1'b0;
        end
        return s;
    endfunction

    function automatic logic value_ok(scan_t s);
        logic r;
        if (s.st.level == '0) begin
            r = !s.st.fl[FL_DONE];
        end else if (s.st.top[2] == 1'b0) begin
            r = (s.st.top[1:0] == 2'd2);
        end else begin
            r = (s.st.top[1:0] == 2'd0);
        end
        return r;
    endfunction

    function automatic scan_t scalar_done(scan_t s, logic [PB-1:0] pos);
        if (s.st.level == '0) begin
            s.st.fl[FL_DONE] = 1'b1;
            s = emit(s, EV_COMPLETE, 8'h00, s.cur);
        end else if (s.st.top[2] == 1'b0) begin
            if (s.st.top[1:0] != 2'd2) begin
                s = fail(s);
            end else begin
                s.st.top[1:0] = 2'd3;
                s = span_end(s, pos);
            end
        end else begin
            if (s.st.top[1:0] != 2'd0) begin
                s = fail(s);
            end else begin
                s.st.top[1:0] = 2'd1;
                s = span_end(s, pos);
            end
        end
        return s;
    endfunction

    function automatic scan_t open_frame(scan_t s, logic [2:0] kind);
        if (s.st.level >= LW'(MAX_DEPTH)) begin
            s = fail(s);
        end else begin
            if (s.st.level != '0) begin
                // spill the old top into the stack memory
                s.push      = 1'b1;
                s.wdata     = s.st.top;
                s.waddr     = AW'(s.st.level - 1'b1);
                s.st.second = s.st.top;
            end
            s.st.top   = kind;
            s.st.level = s.st.level + 1'b1;
        end
        return s;
    endfunction

    function automatic scan_t close_frame(scan_t s, logic arr);
        logic [1:0] sub;
        sub = s.st.top[1:0];
        if (s.st.level == '0 || s.st.top[2] != arr) begin
            s = fail(s);
        end else if (!arr && sub != 2'd0 && sub != 2'd3) begin
            s = fail(s);
        end else if (arr && sub != 2'd0 && sub != 2'd1) begin
            s = fail(s);
        end else begin
            s.st.level = s.st.level - 1'b1;
            s.pop      = 1'b1;
            if (s.st.level == '0) begin
                s.st.fl[FL_DONE] = 1'b1;
                s = emit(s, EV_COMPLETE, 8'h00, s.cur);
            end else begin
                s.st.top = s.st.second;
                if (s.st.top[2] == 1'b0) begin
                    if (s.st.top[1:0] == 2'd2) s.st.top[1:0] = 2'd3;
                end else begin
                    if (s.st.top[1:0] == 2'd0) s.st.top[1:0] = 2'd1;
                end
                s = span_end(s, PB'(s.cur + 1'b1));
            end
        end
        return s;
    endfunction

    function automatic scan_t close_key(scan_t s);
        s = flush_high(s);
        if (s.st.level == LW'(1)) begin
            s.st.fl[FL_HAVEKEY] = 1'b1;
            s = emit(s, EV_KEY_END, 8'h00, s.cur);
        end
        s.st.fl[FL_INKEY] = 1'b0;
        if (s.st.level != '0 && s.st.top[2] == 1'b0 && s.st.top[1:0] == 2'd0) begin
            s.st.top[1:0] = 2'd1;
        end else begin
            s = fail(s);
        end
        return s;
    endfunction

    function automatic scan_t do_normal(scan_t s, logic [7:0] c);
        logic key_pos;
        key_pos = s.st.level != '0 && s.st.top[2] == 1'b0 && s.st.top[1:0] == 2'd0;
        if (is_ws(c)) begin
            s.redo = 1'b0;
        end else if (c == 8'h7B || c == 8'h5B) begin
            if (!value_ok(s)) begin
                s = fail(s);
            end else begin
                s = mark_value_start(s);
                s = open_frame(s, (c == 8'h7B) ? FRAME_OBJ : FRAME_ARR);
            end
        end else if (c == 8'h7D || c == 8'h5D) begin
            s = close_frame(s, c == 8'h5D);
        end else if (c == 8'h3A) begin
            if (s.st.level == '0 || s.st.top[2] || s.st.top[1:0] != 2'd1) begin
                s = fail(s);
            end else begin
                s.st.top[1:0] = 2'd2;
                if (s.st.level == LW'(1) && s.st.fl[FL_HAVEKEY]) s.st.fl[FL_WANT] = 1'b1;
            end
        end else if (c == 8'h2C) begin
            if (s.st.level == '0) begin
                s = fail(s);
            end else if (s.st.top[1:0] == (s.st.top[2] ? 2'd1 : 2'd3)) begin
                s.st.top[1:0] = 2'd0;
            end else begin
                s = fail(s);
            end
        end else if (c == 8'h22) begin
            if (!key_pos && !value_ok(s)) begin
                s = fail(s);
            end else begin
                s = mark_value_start(s);
                if (key_pos) s.st.fl[FL_INKEY] = 1'b1;
                s.st.mode = SM_STR;
            end
        end else if (c == 8'h2D || is_num_char(c)) begin
            if (!value_ok(s)) begin
                s = fail(s);
            end else begin
                s = mark_value_start(s);
                s.st.mode   = SM_NUM;
                s.st.nphase = (c == 8'h2D) ? 3'd0 : 3'd1;
            end
        end else if (c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
            if (!value_ok(s)) begin
                s = fail(s);
            end else begin
                s = mark_value_start(s);
                s.st.mode   = SM_LIT;
                s.st.lwhich = (c == 8'h74) ? 2'd0 : (c == 8'h66) ? 2'd1 : 2'd2;
                s.st.lidx   = 3'd1;
            end
        end else if (c == 8'h2F) begin
            s.st.mode = SM_SLASH;
        end else begin
            s = fail(s);
        end
        return s;
    endfunction

    function automatic scan_t do_hex(scan_t s, logic [7:0] c);
        logic [4:0]  h;
        logic [15:0] cp;
        h = hex_val(c);
        if (!h[4]) begin
            s = fail(s);
        end else begin
            s.st.hacc  = {s.st.hacc[11:0], h[3:0]};
            s.st.hleft = s.st.hleft - 1'b1;
            cp = s.st.hacc;
            if (s.st.hleft == 3'd0) begin
                s.st.mode = SM_STR;
                if (s.st.fl[FL_INKEY]) begin
                    if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                        s = flush_high(s);
                        s.st.hheld = 1'b1;
                        s.st.hval  = cp;
                    end else if (cp >= 16'hDC00 && cp <= 16'hDFFF && s.st.hheld) begin
                        // combine the pair into one supplementary code point
                        s = utf8_out(s, 21'h10000 + 21'({s.st.hval[9:0], cp[9:0]}));
                        s.st.hheld = 1'b0;
                    end else begin
                        s = flush_high(s);
                        s = utf8_out(s, {5'd0, cp});
                    end
                end
            end
        end
        return s;
    endfunction

    function automatic scan_t do_escape(scan_t s, logic [7:0] c);
        logic       put;
        logic [7:0] v;
        put = 1'b1;
        v   = 8'h00;
        case (c)
            8'h75: begin
                s.st.mode  = SM_HEX;
                s.st.hleft = 3'd4;
                s.st.hacc  = 16'd0;
                put        = 1'b0;
            end
            8'h22:   v = 8'h22;
            8'h5C:   v = 8'h5C;
            8'h2F:   v = 8'h2F;
            8'h62:   v = 8'h08;
            8'h66:   v = 8'h0C;
            8'h6E:   v = 8'h0A;
            8'h72:   v = 8'h0D;
            8'h74:   v = 8'h09;
            default: begin
                s   = fail(s);
                put = 1'b0;
            end
        endcase
        if (put) begin
            if (s.st.fl[FL_INKEY]) begin
                s = flush_high(s);
                s = utf8_out(s, {13'd0, v});
            end
            s.st.mode = SM_STR;
        end
        return s;
    endfunction

    function automatic scan_t do_number(scan_t s, logic [7:0] c);
        logic delim, dig, ended, expo;
        delim = is_ws(c) || c inside {8'h2C, 8'h7D, 8'h5D, 8'h2F};
        dig   = is_num_char(c);
        expo  = (c == 8'h65 || c == 8'h45);
        ended = 1'b0;
        case (s.st.nphase)
            3'd0: if (dig) s.st.nphase = 3'd1; else s = fail(s);
            3'd1: begin
                if (c == 8'h2E) s.st.nphase = 3'd2;
                else if (expo) s.st.nphase = 3'd4;
                else if (!dig) ended = 1'b1;
            end
            3'd2: if (dig) s.st.nphase = 3'd3; else s = fail(s);
            3'd3: begin
                if (expo) s.st.nphase = 3'd4;
                else if (!dig) ended = 1'b1;
            end
            3'd4: begin
                if (dig) s.st.nphase = 3'd6;
                else if (c == 8'h2B || c == 8'h2D) s.st.nphase = 3'd5;
                else s = fail(s);
            end
            3'd5: if (dig) s.st.nphase = 3'd6; else s = fail(s);
            3'd6: if (!dig) ended = 1'b1;
            default: s = fail(s);
        endcase
        if (ended) begin
            if (!delim) begin
                s = fail(s);
            end else begin
                s.st.mode = SM_NORMAL;
                s = scalar_done(s, s.cur);
                // hand the delimiter on to the structural scan
                s.redo = !s.st.fl[FL_ERR];
            end
        end
        return s;
    endfunction

    function automatic scan_t do_literal(scan_t s, logic [7:0] c);
        logic [2:0] len;
        len = lit_len(s.st.lwhich);
        if (s.st.lidx >= len || c != lit_char(s.st.lwhich, s.st.lidx)) begin
            s = fail(s);
        end else begin
            s.st.lidx = s.st.lidx + 1'b1;
            if (s.st.lidx == len) begin
                s.st.mode = SM_NORMAL;
                s = scalar_done(s, PB'(s.cur + 1'b1));
            end
        end
        return s;
    endfunction

    function automatic scan_t step_byte(scan_t s, logic [7:0] c);
        case (s.st.mode)
            SM_NORMAL: s = do_normal(s, c);
            SM_STR: begin
                if (c == 8'h22) begin
                    if (s.st.fl[FL_INKEY]) s = close_key(s);
                    else s = scalar_done(s, PB'(s.cur + 1'b1));
                    s.st.mode = SM_NORMAL;
                end else if (c == 8'h5C) begin
                    s.st.mode = SM_ESC;
                end else if (s.st.fl[FL_INKEY]) begin
                    s = flush_high(s);
                    s = key_out(s, c);
                end
            end
            SM_ESC:   s = do_escape(s, c);
            SM_HEX:   s = do_hex(s, c);
            SM_LINE:  if (c == 8'h0A) s.st.mode = SM_NORMAL;
            SM_BLOCK: if (c == 8'h2A) s.st.mode = SM_STAR;
            SM_STAR: begin
                if (c == 8'h2F) s.st.mode = SM_NORMAL;
                else if (c != 8'h2A) s.st.mode = SM_BLOCK;
            end
            SM_SLASH: begin
                if (c == 8'h2F) s.st.mode = SM_LINE;
                else if (c == 8'h2A) s.st.mode = SM_BLOCK;
                else s = fail(s);
            end
            SM_NUM: begin
                s = do_number(s, c);
                if (s.redo) s = do_normal(s, c);
            end
            SM_LIT:  s = do_literal(s, c);
            default: s = fail(s);
        endcase
        return s;
    endfunction

    always_comb begin
        scan           = '0;
        scan.st        = st_reg;
        scan.st.second = use_ram_reg ? ram_rdata : st_reg.second;
        scan.cur       = idx_reg;
        if (in_cmd == CMD_CLEAR) begin
            scan.st = ST_CLEAR;
            scan    = emit(scan, EV_PROGRESS, 8'h00, '0);
        end else begin
            if (st_reg.fl[FL_ERR]) scan = emit(scan, EV_IGNORED, 8'h00, idx_reg);
            else scan = step_byte(scan, in_byte);
            if (scan.cnt == '0) scan = emit(scan, EV_PROGRESS, 8'h00, idx_reg);
        end
    end

    assign accept           = in_valid && in_ready;
    assign out_valid        = in_valid;
    assign out_bundle.ev    = scan.ev;
    assign out_bundle.cnt   = scan.cnt;
    assign out_bundle.depth = 6'(scan.st.level);

    always_comb begin
        st_next        = st_reg;
        st_next.second = use_ram_reg ? ram_rdata : st_reg.second;
        use_ram_next   = 1'b0;
        idx_next       = idx_reg;
        if (accept) begin
            st_next      = scan.st;
            use_ram_next = scan.pop && in_cmd == CMD_DATA;
            idx_next     = (in_cmd == CMD_CLEAR) ? '0 : PB'(idx_reg + 1'b1);
        end
    end

    // fetch the frame below the new top so it is ready after a close
    assign ram_raddr = (st_next.level >= LW'(2)) ? AW'(st_next.level - LW'(2)) : '0;
    assign ram_we    = accept && in_cmd == CMD_DATA && scan.push;

    jsc_ram #(
        .WIDTH (3),
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (scan.waddr),
        .wdata (scan.wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLEAR;
            idx_reg     <= '0;
            use_ram_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            idx_reg     <= idx_next;
            use_ram_reg <= use_ram_next;
        end
    end

endmodule

// ===== sv/jsc_queue.sv =====
`timescale 1ns / 1ps
module jsc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  jsc_pkg::bundle_t in_bundle,
    output logic             out_valid,
    input  logic             out_ready,
    output jsc_pkg::bundle_t out_bundle
);
    import jsc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    bundle_t       slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          push, pop;

    assign in_ready   = fill_reg != CW'(QUEUE_DEPTH);
    assign out_valid  = fill_reg != '0;
    assign out_bundle = slot_reg[rd_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;

    always_comb begin
        wr_next   = push ? PW'(wr_reg + 1'b1) : wr_reg;
        rd_next   = pop ? PW'(rd_reg + 1'b1) : rd_reg;
        fill_next = fill_reg;
        if (push && !pop) fill_next = fill_reg + 1'b1;
        else if (pop && !push) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== sv/jsc_back.sv =====
`timescale 1ns / 1ps
module jsc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  jsc_pkg::bundle_t              in_bundle,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jsc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import jsc_pkg::*;

    logic [EV_IDX_W-1:0]  sel_reg, sel_next;
    logic                 valid_reg, valid_next;
    logic [M_TDATA_W-1:0] data_reg, data_next;
    logic                 last_reg, last_next;
    logic                 load, final_word;
    event_t               cur_ev;

    assign cur_ev     = in_bundle.ev[sel_reg];
    assign final_word = (CNT_W'(sel_reg) + 1'b1) == in_bundle.cnt;
    assign load       = in_valid && (!valid_reg || m_tready);
    // release the queue slot with its last word
    assign in_ready   = load && final_word;

    always_comb begin
        sel_next   = sel_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {(M_TDATA_W - M_FIELD_W)'(0), in_bundle.depth, cur_ev.pos,
                          cur_ev.key, cur_ev.code};
            last_next  = final_word;
            sel_next   = final_word ? '0 : EV_IDX_W'(sel_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== sv/jsc_checker.sv =====
`timescale 1ns / 1ps
module jsc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [jsc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import jsc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == EV_ERROR |-> m_tlast)
        else $error("error word not last of its byte");

    a_complete_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == EV_COMPLETE |-> m_tdata[48:43] == 6'd0)
        else $error("document complete with open nesting");

    a_key_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == EV_KEY_BYTE |-> m_tdata[48:43] == 6'd1)
        else $error("key byte outside the outermost object");

    a_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != EV_KEY_BYTE |-> m_tdata[10:3] == 8'd0)
        else $error("key byte field set on a non-key word");

endmodule

bind streaming_json_syntax_checker jsc_checker u_jsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/streaming_json_syntax_checker_tb.sv =====
`timescale 1ns / 1ps
module streaming_json_syntax_checker_tb;
    import jsc_pkg::*;

    localparam int DEPTH_LIMIT = 32;

    typedef struct packed {
        ev_code_t    code;
        logic [7:0]  key;
        logic [31:0] pos;
        logic [5:0]  depth;
        logic        last;
    } result_t;

    // frame kinds and sub-positions
    localparam logic [2:0] KIND_ARR = 3'b100;
    localparam logic [1:0] OBJ_WANT_KEY = 2'd0, OBJ_WANT_COLON = 2'd1,
                           OBJ_WANT_VAL = 2'd2, OBJ_WANT_SEP = 2'd3;
    localparam logic [1:0] ARR_WANT_VAL = 2'd0, ARR_WANT_SEP = 2'd1;

    typedef enum logic [3:0] {
        M_NORMAL, M_STR, M_ESC, M_HEX, M_LINE, M_BLOCK, M_STAR, M_NUM, M_LIT, M_SLASH
    } scan_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    streaming_json_syntax_checker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // scanner copy
    scan_t       mode;
    logic [2:0]  num_ph;
    logic [1:0]  lit_sel;
    logic [2:0]  lit_pos;
    logic [2:0]  hex_left;
    logic [15:0] hex_acc;
    logic        hi_held;
    logic [15:0] hi_val;
    logic        in_key, have_key, want_span, doc_done, failed;
    logic [2:0]  frames [DEPTH_LIMIT];
    int          level;
    logic [31:0] byte_count;
    logic [31:0] here;

    result_t     pending [$];
    result_t     step_events [$];
    int          errors = 0;
    int          results_seen = 0;
    int          keys_seen = 0;
    bit          quiet = 1'b0;

    function automatic void push_event(ev_code_t c, logic [7:0] k, logic [31:0] p);
        result_t r;
        if (step_events.size() < EV_MAX) begin
            r.code = c; r.key = k; r.pos = p; r.depth = '0; r.last = 1'b0;
            step_events.insert(step_events.size(), r);
        end
    endfunction

    function automatic void scanner_clear();
        mode = M_NORMAL; num_ph = 0; lit_sel = 0; lit_pos = 0; hex_left = 0; hex_acc = 0;
        hi_held = 0; hi_val = 0;
        in_key = 0; have_key = 0; want_span = 0; doc_done = 0; failed = 0;
        level = 0; byte_count = 0;
    endfunction

    function automatic void raise_error();
        failed = 1'b1;
        push_event(EV_ERROR, 8'h00, here);
    endfunction

    function automatic logic [2:0] top_kind();
        return frames[level-1] & KIND_ARR;
    endfunction

    function automatic logic [1:0] top_sub();
        return frames[level-1][1:0];
    endfunction

    function automatic void set_sub(logic [1:0] s);
        frames[level-1] = top_kind() | {1'b0, s};
    endfunction

    function automatic void key_emit(logic [7:0] b);
        if (level == 1) push_event(EV_KEY_BYTE, b, here);
    endfunction

    function automatic void utf8_emit(logic [31:0] cp);
        if (cp < 32'h80) key_emit(cp[7:0]);
        else if (cp < 32'h800) begin
            key_emit(8'hC0 | {3'b000, cp[10:6]});
            key_emit(8'h80 | {2'b00, cp[5:0]});
        end else if (cp < 32'h10000) begin
            key_emit(8'hE0 | {4'h0, cp[15:12]});
            key_emit(8'h80 | {2'b00, cp[11:6]});
            key_emit(8'h80 | {2'b00, cp[5:0]});
        end else begin
            key_emit(8'hF0 | {5'd0, cp[20:18]});
            key_emit(8'h80 | {2'b00, cp[17:12]});
            key_emit(8'h80 | {2'b00, cp[11:6]});
            key_emit(8'h80 | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic void release_high();
        if (hi_held) begin
            utf8_emit({16'h0, hi_val});
            hi_held = 1'b0;
        end
    endfunction

    function automatic void note_value_start();
        if (level == 1 && want_span) begin
            push_event(EV_VALUE_START, 8'h00, here);
            want_span = 1'b0;
        end
    endfunction

    function automatic void note_value_end(logic [31:0] end_pos);
        if (level == 1 && have_key && !want_span) begin
            push_event(EV_VALUE_END, 8'h00, end_pos);
            have_key = 1'b0;
            want_span = 1'b0;
        end
    endfunction

    function automatic void scalar_end(logic [31:0] end_pos);
        if (level == 0) begin
            doc_done = 1'b1;
            push_event(EV_COMPLETE, 8'h00, here);
            return;
        end
        if (top_kind() != KIND_ARR) begin
            if (top_sub() != OBJ_WANT_VAL) begin raise_error(); return; end
            set_sub(OBJ_WANT_SEP);
        end else begin
            if (top_sub() != ARR_WANT_VAL) begin raise_error(); return; end
            set_sub(ARR_WANT_SEP);
        end
        note_value_end(end_pos);
    endfunction

    function automatic bit value_allowed();
        if (level == 0) return !doc_done;
        return top_kind() != KIND_ARR ? top_sub() == OBJ_WANT_VAL : top_sub() == ARR_WANT_VAL;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void enter_frame(logic [2:0] kind);
        if (level >= DEPTH_LIMIT) begin raise_error(); return; end
        frames[level] = kind;
        level++;
    endfunction

    function automatic void leave_frame(logic [2:0] kind);
        logic [1:0] s;
        if (level == 0 || top_kind() != kind) begin raise_error(); return; end
        s = top_sub();
        if (kind != KIND_ARR ? (s != OBJ_WANT_KEY && s != OBJ_WANT_SEP)
                             : (s != ARR_WANT_VAL && s != ARR_WANT_SEP)) begin
            raise_error();
            return;
        end
        level--;
        if (level == 0) begin
            doc_done = 1'b1;
            push_event(EV_COMPLETE, 8'h00, here);
            return;
        end
        if (top_kind() != KIND_ARR) begin
            if (top_sub() == OBJ_WANT_VAL) set_sub(OBJ_WANT_SEP);
        end else if (top_sub() == ARR_WANT_VAL) set_sub(ARR_WANT_SEP);
        note_value_end(here + 1);
    endfunction

    function automatic void end_key();
        release_high();
        if (level == 1) begin
            have_key = 1'b1;
            push_event(EV_KEY_END, 8'h00, here);
        end
        in_key = 1'b0;
        if (level > 0 && top_kind() != KIND_ARR && top_sub() == OBJ_WANT_KEY)
            set_sub(OBJ_WANT_COLON);
        else raise_error();
    endfunction

    function automatic void structural(logic [7:0] c);
        bit key_slot;
        if (is_ws(c)) return;
        if (c == "{" || c == "[") begin
            if (!value_allowed()) begin raise_error(); return; end
            note_value_start();
            enter_frame(c == "{" ? 3'b000 : KIND_ARR);
        end else if (c == "}" || c == "]") begin
            leave_frame(c == "}" ? 3'b000 : KIND_ARR);
        end else if (c == ":") begin
            if (level == 0 || top_kind() == KIND_ARR || top_sub() != OBJ_WANT_COLON) begin
                raise_error();
                return;
            end
            set_sub(OBJ_WANT_VAL);
            if (level == 1 && have_key) want_span = 1'b1;
        end else if (c == ",") begin
            if (level == 0) begin raise_error(); return; end
            if (top_kind() != KIND_ARR) begin
                if (top_sub() == OBJ_WANT_SEP) set_sub(OBJ_WANT_KEY); else raise_error();
            end else begin
                if (top_sub() == ARR_WANT_SEP) set_sub(ARR_WANT_VAL); else raise_error();
            end
        end else if (c == "\"") begin
            key_slot = level > 0 && top_kind() != KIND_ARR && top_sub() == OBJ_WANT_KEY;
            if (!key_slot && !value_allowed()) begin raise_error(); return; end
            note_value_start();
            if (key_slot) in_key = 1'b1;
            mode = M_STR;
        end else if (c == "-" || is_dig(c)) begin
            if (!value_allowed()) begin raise_error(); return; end
            note_value_start();
            mode = M_NUM;
            num_ph = (c == "-") ? 3'd0 : 3'd1;
        end else if (c == "t" || c == "f" || c == "n") begin
            if (!value_allowed()) begin raise_error(); return; end
            note_value_start();
            mode = M_LIT;
            lit_sel = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
            lit_pos = 3'd1;
        end else if (c == "/") begin
            mode = M_SLASH;
        end else raise_error();
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (is_dig(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void hex_step(logic [7:0] c);
        int h;
        h = hex_digit(c);
        if (h < 0) begin raise_error(); return; end
        hex_acc = {hex_acc[11:0], h[3:0]};
        hex_left = hex_left - 3'd1;
        if (hex_left != 0) return;
        mode = M_STR;
        if (!in_key) return;
        if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
            release_high();
            hi_held = 1'b1;
            hi_val = hex_acc;
        end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF && hi_held) begin
            utf8_emit(32'h10000 + ((32'(hi_val) - 32'hD800) << 10) + (32'(hex_acc) - 32'hDC00));
            hi_held = 1'b0;
        end else begin
            release_high();
            utf8_emit({16'h0, hex_acc});
        end
    endfunction

    function automatic void escape_step(logic [7:0] c);
        logic [7:0] v;
        case (c)
            "u": begin mode = M_HEX; hex_left = 3'd4; hex_acc = '0; return; end
            "\"", "\\", "/": v = c;
            "b": v = 8'h08;
            "f": v = 8'h0C;
            "n": v = 8'h0A;
            "r": v = 8'h0D;
            "t": v = 8'h09;
            default: begin raise_error(); return; end
        endcase
        if (in_key) begin release_high(); utf8_emit({24'h0, v}); end
        mode = M_STR;
    endfunction

    // true when the number ended and the byte must be seen again as structure
    function automatic bit number_step(logic [7:0] c);
        bit delim, dig;
        delim = is_ws(c) || c == "," || c == "}" || c == "]" || c == "/";
        dig = is_dig(c);
        case (num_ph)
            3'd0: begin if (dig) num_ph = 3'd1; else raise_error(); return 0; end
            3'd1: begin
                if (dig) return 0;
                if (c == ".") begin num_ph = 3'd2; return 0; end
                if (c == "e" || c == "E") begin num_ph = 3'd4; return 0; end
            end
            3'd2: begin if (dig) num_ph = 3'd3; else raise_error(); return 0; end
            3'd3: begin
                if (dig) return 0;
                if (c == "e" || c == "E") begin num_ph = 3'd4; return 0; end
            end
            3'd4: begin
                if (dig) num_ph = 3'd6;
                else if (c == "+" || c == "-") num_ph = 3'd5;
                else raise_error();
                return 0;
            end
            3'd5: begin if (dig) num_ph = 3'd6; else raise_error(); return 0; end
            3'd6: if (dig) return 0;
            default: begin raise_error(); return 0; end
        endcase
        if (!delim) begin raise_error(); return 0; end
        mode = M_NORMAL;
        scalar_end(here);
        return !failed;
    endfunction

    function automatic void literal_step(logic [7:0] c);
        string words [3];
        words[0] = "true"; words[1] = "false"; words[2] = "null";
        if (lit_sel > 2 || lit_pos >= words[lit_sel].len() || c != words[lit_sel][lit_pos]) begin
            raise_error();
            return;
        end
        lit_pos++;
        if (lit_pos == words[lit_sel].len()) begin
            mode = M_NORMAL;
            scalar_end(here + 1);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        case (mode)
            M_NORMAL: structural(c);
            M_STR: begin
                if (c == "\"") begin
                    if (in_key) end_key(); else scalar_end(here + 1);
                    mode = M_NORMAL;
                end else if (c == "\\") mode = M_ESC;
                else if (in_key) begin release_high(); key_emit(c); end
            end
            M_ESC:   escape_step(c);
            M_HEX:   hex_step(c);
            M_LINE:  if (c == 8'h0A) mode = M_NORMAL;
            M_BLOCK: if (c == "*") mode = M_STAR;
            M_STAR:  begin
                if (c == "/") mode = M_NORMAL;
                else if (c != "*") mode = M_BLOCK;
            end
            M_SLASH: begin
                if (c == "/") mode = M_LINE;
                else if (c == "*") mode = M_BLOCK;
                else raise_error();
            end
            M_NUM:   if (number_step(c)) structural(c);
            M_LIT:   literal_step(c);
            default: raise_error();
        endcase
    endfunction

    // work out the result words of one input word and queue them
    function automatic void predict_words(logic cmd, logic [7:0] b);
        result_t r;
        step_events.delete();
        if (cmd == CMD_CLEAR) begin
            scanner_clear();
            push_event(EV_PROGRESS, 8'h00, 32'h0);
        end else begin
            here = byte_count;
            byte_count++;
            if (failed) push_event(EV_IGNORED, 8'h00, here);
            else scan_byte(b);
            if (step_events.size() == 0) push_event(EV_PROGRESS, 8'h00, here);
        end
        foreach (step_events[i]) begin
            r = step_events[i];
            r.depth = level[5:0];
            r.last = (i == step_events.size() - 1);
            pending.insert(pending.size(), r);
        end
    endfunction

    // result side: random stalls, check each word against the oldest expectation
    initial begin
        int stall;
        result_t got, want;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.code = ev_code_t'(m_tdata[2:0]);
                got.key = m_tdata[10:3];
                got.pos = m_tdata[42:11];
                got.depth = m_tdata[48:43];
                got.last = m_tlast;
                results_seen++;
                if (got.code == EV_KEY_BYTE) keys_seen++;
                if (pending.size() == 0) begin
                    errors++;
                    $display("%0t: expected no word, actual %p", $time, got);
                end else begin
                    want = pending.pop_front();
                    if (got !== want || m_tdata[55:49] !== '0) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (quiet) m_tready <= 1'b1;
            else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    initial begin
        #20ms;
        $display("** streaming_json_syntax_checker: FAILED **");
        $finish;
    end

    typedef struct {
        logic       cmd;
        logic [7:0] b;
        bit         fixed;   // expected word typed in below
        ev_code_t   code;
        logic [31:0] pos;
    } row_t;

    logic       txt_cmd [$];
    logic [7:0] txt_byte [$];
    int         sent = 0;

    task automatic send_word(logic cmd, logic [7:0] b, bit gaps);
        if (gaps && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= b;
        predict_words(cmd, b);
        sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            txt_cmd.insert(txt_cmd.size(), CMD_DATA);
            txt_byte.insert(txt_byte.size(), s[i]);
        end
    endfunction

    function automatic void add_doc();
        string keys [6];
        string vals [10];
        int n;
        keys[0] = "\"ab\""; keys[1] = "\"k\\n\\u00e9\"";
        keys[2] = "\"\\ud83d\\ude00x\""; keys[3] = "\"\\ud800y\\udc01\"";
        keys[4] = "\"\\u20AC\\/\""; keys[5] = "\"\\uD834\"";
        vals[0] = "-12.5e+3"; vals[1] = "true"; vals[2] = "null"; vals[3] = "false";
        vals[4] = "[1, {\"q\":[]}, ]"; vals[5] = "\"s\\t\\\"\""; vals[6] = "{}";
        vals[7] = "0E7 "; vals[8] = "[[[\"x\"]]]"; vals[9] = "/*c**/ 7";
        txt_cmd.insert(txt_cmd.size(), CMD_CLEAR);
        txt_byte.insert(txt_byte.size(), 8'($urandom));
        add_text("{");
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) add_text(" // x\n");
            add_text(keys[$urandom_range(0, 5)]);
            add_text($urandom_range(0, 1) ? ":" : " : ");
            add_text(vals[$urandom_range(0, 9)]);
            if (i < n - 1 || $urandom_range(0, 1)) add_text(",");
        end
        add_text("}\n");
        if ($urandom_range(0, 4) == 0) begin
            // corrupt one byte of the document
            txt_byte[txt_byte.size() - $urandom_range(1, 6)] = 8'($urandom);
        end
    endfunction

    initial begin
        row_t rows [$];
        row_t r;
        result_t head;
        string deep;
        scanner_clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, errors and each special case
        r = '{CMD_CLEAR, 8'hFF, 1, EV_PROGRESS, 0}; rows.insert(rows.size(), r);
        r = '{CMD_DATA, 8'h00, 1, EV_ERROR, 0}; rows.insert(rows.size(), r);
        r = '{CMD_DATA, 8'hFF, 1, EV_IGNORED, 1}; rows.insert(rows.size(), r);
        r = '{CMD_CLEAR, 8'h00, 1, EV_PROGRESS, 0}; rows.insert(rows.size(), r);
        r = '{CMD_DATA, "/", 1, EV_PROGRESS, 0}; rows.insert(rows.size(), r);
        r = '{CMD_DATA, "x", 1, EV_ERROR, 1}; rows.insert(rows.size(), r);
        r = '{CMD_CLEAR, 8'h00, 1, EV_PROGRESS, 0}; rows.insert(rows.size(), r);
        foreach (rows[i]) begin
            send_word(rows[i].cmd, rows[i].b, 1'b0);
            if (rows[i].fixed) begin
                head = pending[pending.size() - 1];
                if (head.code !== rows[i].code || head.pos !== rows[i].pos) begin
                    errors++;
                    $display("%0t: table row %0d expected %s at %0d predicted %s at %0d",
                             $time, i, rows[i].code.name(), rows[i].pos,
                             head.code.name(), head.pos);
                end
            end
        end
        // too deep, then completion followed by a stray token, then a bad escape in a key
        deep = "";
        for (int i = 0; i < DEPTH_LIMIT + 1; i++) deep = {deep, "["};
        add_text(deep);
        txt_cmd.insert(txt_cmd.size(), CMD_CLEAR); txt_byte.insert(txt_byte.size(), 8'h00);
        add_text("{\"k\\ud800\":1}\t1");
        txt_cmd.insert(txt_cmd.size(), CMD_CLEAR); txt_byte.insert(txt_byte.size(), 8'h00);
        add_text("{\"\\udc00\\q");
        while (txt_cmd.size() > 0) send_word(txt_cmd.pop_front(), txt_byte.pop_front(), 1'b0);

        // hold off until every expected word is back
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        @(posedge aclk);

        // random: mostly well-formed documents, some noise
        while (sent < 360) begin
            if ($urandom_range(0, 5) == 0) begin
                for (int i = 0; i < 4; i++) begin
                    txt_cmd.insert(txt_cmd.size(),
                                   $urandom_range(0, 9) == 0 ? CMD_CLEAR : CMD_DATA);
                    txt_byte.insert(txt_byte.size(), 8'($urandom));
                end
            end else add_doc();
            if (sent > 320) quiet = 1'b1;
            while (txt_cmd.size() > 0)
                send_word(txt_cmd.pop_front(), txt_byte.pop_front(), !quiet);
        end
        s_tvalid <= 1'b0;
        quiet = 1'b1;
        while (pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d words; checked %0d result words, %0d of them key bytes.",
                 sent, results_seen, keys_seen);
        if (errors == 0) $display("** streaming_json_syntax_checker: PASSED **");
        else $display("** streaming_json_syntax_checker: FAILED **");
        $finish;
    end
endmodule
